### rtl/core/cpcr_pkg.sv
// shared types and constants of the circle pair collision resolve block
package cpcr_pkg;

  localparam int WORD_W  = 32;  // Q16.16 word
  localparam int DIFF_W  = 33;  // exact coordinate difference
  localparam int SQ_W    = 66;  // sum of two squared differences
  localparam int ROOT_W  = 33;  // distance, integer square root of the sum
  localparam int RAD_W   = 27;  // radius register
  localparam int NUM_W   = DIFF_W + RAD_W;  // |d| * radius
  localparam int QUO_W   = RAD_W;           // |d| * radius / L stays below 2^27

  localparam logic [RAD_W-1:0] RADIUS_RESET = 27'd655360;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for any 32-bit x
  localparam logic [32:0] RECIP_100   = 33'd5497558139;
  localparam int          RECIP_SHIFT = 39;
  localparam logic [31:0] DAMP_ROUND  = 32'd99;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_a_x;
    logic signed [WORD_W-1:0] pos_a_y;
    logic signed [WORD_W-1:0] pos_b_x;
    logic signed [WORD_W-1:0] pos_b_y;
    logic signed [WORD_W-1:0] vel_a_x;
    logic signed [WORD_W-1:0] vel_a_y;
    logic signed [WORD_W-1:0] vel_b_x;
    logic signed [WORD_W-1:0] vel_b_y;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_pos_a_x;
    logic signed [WORD_W-1:0] new_pos_a_y;
    logic signed [WORD_W-1:0] new_pos_b_x;
    logic signed [WORD_W-1:0] new_pos_b_y;
    logic signed [WORD_W-1:0] new_vel_a_x;
    logic signed [WORD_W-1:0] new_vel_a_y;
    logic signed [WORD_W-1:0] new_vel_b_x;
    logic signed [WORD_W-1:0] new_vel_b_y;
  } out_t;

endpackage

### rtl/core/cpcr_if.sv
// request channel interfaces for circle pairs and resolved results
interface cpcr_in_if import cpcr_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpcr_out_if import cpcr_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/circle_pair_collision_resolve_unit.sv
// top level: pipelined overlap resolution and velocity damping for a pair of circles
//
//   channel   dir   handshake           payload
//   in_i      in    valid/ready         two positions, two velocities
//   out_o     out   valid/ready         resolved positions, damped velocities
//   cfg       in    cfg_we_i            radius, 27 bits
//
// one request enters per cycle unless the output stalls; every result passes
// three front stages, 33 square root stages, one product stage, 27 divider stages
// and the output register. the square root and the divider set the depth.
// reset clears all valid bits and loads the radius with 10.0.
// a stalled output freezes the whole pipeline, in_i.ready drops with it.
module circle_pair_collision_resolve_unit import cpcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RAD_W-1:0]  cfg_wdata_i,
  cpcr_in_if.sink           in_i,
  cpcr_out_if.source        out_o
);

  // side data carried along the square root
  typedef struct packed {
    logic signed [WORD_W-1:0] ax, ay, bx, by;
    logic [DIFF_W-1:0]        mx, my;
    logic                     sgx, sgy;
    logic [WORD_W-1:0]        dv0, dv1, dv2, dv3;
  } sq_aux_t;

  // side data carried along the divider
  typedef struct packed {
    logic signed [WORD_W-1:0] ax, ay, bx, by;
    logic [WORD_W-1:0]        hx, hy;
    logic                     sgx, sgy, zero;
    logic [WORD_W-1:0]        dv0, dv1, dv2, dv3;
  } dv_aux_t;

  localparam int SQ_AUX_W = $bits(sq_aux_t);
  localparam int DV_AUX_W = $bits(dv_aux_t);

  logic [RAD_W-1:0] radius_q;
  logic             adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // the pipeline moves whenever the output register can take a new result
  logic out_valid_q;
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- stage 1: differences and velocity reciprocal products
  logic [DIFF_W-1:0]        dx, dy, mx, my;
  logic [WORD_W-1:0]        vmag [4];
  logic [WORD_W-1:0]        vsel [4];
  logic [64:0]              vprod [4];

  logic                     v1_q;
  logic signed [WORD_W-1:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic [DIFF_W-1:0]        mx1_q, my1_q;
  logic                     sgx1_q, sgy1_q;
  logic [WORD_W-1:0]        vm1_q [4];
  logic [25:0]              vq1_q [4];
  logic                     vs1_q [4];

  always_comb begin
    dx = {in_i.data.pos_a_x[WORD_W-1], in_i.data.pos_a_x}
       - {in_i.data.pos_b_x[WORD_W-1], in_i.data.pos_b_x};
    dy = {in_i.data.pos_a_y[WORD_W-1], in_i.data.pos_a_y}
       - {in_i.data.pos_b_y[WORD_W-1], in_i.data.pos_b_y};
    mx = dx[DIFF_W-1] ? -dx : dx;
    my = dy[DIFF_W-1] ? -dy : dy;
    vsel[0] = in_i.data.vel_a_x;
    vsel[1] = in_i.data.vel_a_y;
    vsel[2] = in_i.data.vel_b_x;
    vsel[3] = in_i.data.vel_b_y;
    for (int i = 0; i < 4; i++) begin
      vmag[i]  = vsel[i][WORD_W-1] ? -vsel[i] : vsel[i];
      // ceil(n/100) = floor((n+99)/100)
      vprod[i] = (vmag[i] + DAMP_ROUND) * RECIP_100;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax1_q  <= in_i.data.pos_a_x;
      ay1_q  <= in_i.data.pos_a_y;
      bx1_q  <= in_i.data.pos_b_x;
      by1_q  <= in_i.data.pos_b_y;
      mx1_q  <= mx;
      my1_q  <= my;
      sgx1_q <= dx[DIFF_W-1];
      sgy1_q <= dy[DIFF_W-1];
      for (int i = 0; i < 4; i++) begin
        vm1_q[i] <= vmag[i];
        vq1_q[i] <= vprod[i][64:RECIP_SHIFT];
        vs1_q[i] <= vsel[i][WORD_W-1];
      end
    end
  end

  // ---------------- stage 2: squares and damped velocities
  logic [2*DIFF_W-1:0] sqx, sqy;
  logic [WORD_W-1:0]   dv [4];

  logic                v2_q;
  logic [SQ_W-2:0]     sx2_q, sy2_q;
  sq_aux_t             a2_q;

  always_comb begin
    sqx = mx1_q * mx1_q;
    sqy = my1_q * my1_q;
    for (int i = 0; i < 4; i++) begin
      // 99n/100 = n - ceil(n/100), sign restored afterwards
      dv[i] = vm1_q[i] - {6'b0, vq1_q[i]};
      dv[i] = vs1_q[i] ? -dv[i] : dv[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx2_q    <= sqx[SQ_W-2:0];
      sy2_q    <= sqy[SQ_W-2:0];
      a2_q.ax  <= ax1_q;
      a2_q.ay  <= ay1_q;
      a2_q.bx  <= bx1_q;
      a2_q.by  <= by1_q;
      a2_q.mx  <= mx1_q;
      a2_q.my  <= my1_q;
      a2_q.sgx <= sgx1_q;
      a2_q.sgy <= sgy1_q;
      a2_q.dv0 <= dv[0];
      a2_q.dv1 <= dv[1];
      a2_q.dv2 <= dv[2];
      a2_q.dv3 <= dv[3];
    end
  end

  // ---------------- stage 3: squared distance
  logic            v3_q;
  logic [SQ_W-1:0] sum3_q;
  sq_aux_t         a3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum3_q <= {1'b0, sx2_q} + {1'b0, sy2_q};
      a3_q   <= a2_q;
    end
  end

  // ---------------- distance
  logic                sq_valid;
  logic [ROOT_W-1:0]   len;
  logic [SQ_AUX_W-1:0] sq_aux_raw;
  sq_aux_t             sq_aux;

  cpcr_sqrt #(
    .AUX_W (SQ_AUX_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .aux_i   (SQ_AUX_W'(a3_q)),
    .valid_o (sq_valid),
    .root_o  (len),
    .aux_o   (sq_aux_raw)
  );

  assign sq_aux = sq_aux_t'(sq_aux_raw);

  // ---------------- stage 4: |d| * radius
  logic              v4_q;
  logic [NUM_W-1:0]  px4_q, py4_q;
  logic [ROOT_W-1:0] len4_q;
  dv_aux_t           a4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px4_q     <= sq_aux.mx * radius_q;
      py4_q     <= sq_aux.my * radius_q;
      len4_q    <= len;
      a4_q.ax   <= sq_aux.ax;
      a4_q.ay   <= sq_aux.ay;
      a4_q.bx   <= sq_aux.bx;
      a4_q.by   <= sq_aux.by;
      a4_q.hx   <= sq_aux.mx[DIFF_W-1:1];
      a4_q.hy   <= sq_aux.my[DIFF_W-1:1];
      a4_q.sgx  <= sq_aux.sgx;
      a4_q.sgy  <= sq_aux.sgy;
      a4_q.zero <= (len == '0);
      a4_q.dv0  <= sq_aux.dv0;
      a4_q.dv1  <= sq_aux.dv1;
      a4_q.dv2  <= sq_aux.dv2;
      a4_q.dv3  <= sq_aux.dv3;
    end
  end

  // ---------------- |d| * radius / L, truncated
  logic                dv_valid;
  logic [QUO_W-1:0]    qx, qy;
  logic [DV_AUX_W-1:0] dv_aux_raw;
  dv_aux_t             fa;

  cpcr_div #(
    .AUX_W (DV_AUX_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .num_x_i (px4_q),
    .num_y_i (py4_q),
    .den_i   (len4_q),
    .aux_i   (DV_AUX_W'(a4_q)),
    .valid_o (dv_valid),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .aux_o   (dv_aux_raw)
  );

  assign fa = dv_aux_t'(dv_aux_raw);

  // ---------------- output stage: offsets, saturating adds
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [WORD_W+2:0] v);
    logic [WORD_W-1:0] r;
    if (v > $signed({3'b000, 1'b0, {(WORD_W-1){1'b1}}})) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < $signed({3'b111, 1'b1, {(WORD_W-1){1'b0}}})) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  logic signed [WORD_W+1:0] omx, omy, offx, offy;
  logic signed [WORD_W+2:0] nax, nay, nbx, nby;
  out_t                     res_q;

  always_comb begin
    // magnitude of the push, sign of the axis applied after
    omx  = $signed({7'b0, qx}) - $signed({2'b0, fa.hx});
    omy  = $signed({7'b0, qy}) - $signed({2'b0, fa.hy});
    offx = fa.zero ? '0 : (fa.sgx ? -omx : omx);
    offy = fa.zero ? '0 : (fa.sgy ? -omy : omy);
    nax  = {{3{fa.ax[WORD_W-1]}}, fa.ax} + {offx[WORD_W+1], offx};
    nay  = {{3{fa.ay[WORD_W-1]}}, fa.ay} + {offy[WORD_W+1], offy};
    nbx  = {{3{fa.bx[WORD_W-1]}}, fa.bx} - {offx[WORD_W+1], offx};
    nby  = {{3{fa.by[WORD_W-1]}}, fa.by} - {offy[WORD_W+1], offy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.new_pos_a_x <= sat_word(nax);
      res_q.new_pos_a_y <= sat_word(nay);
      res_q.new_pos_b_x <= sat_word(nbx);
      res_q.new_pos_b_y <= sat_word(nby);
      res_q.new_vel_a_x <= fa.dv0;
      res_q.new_vel_a_y <= fa.dv1;
      res_q.new_vel_b_x <= fa.dv2;
      res_q.new_vel_b_y <= fa.dv3;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

endmodule

### rtl/core/cpcr_sqrt.sv
// pipelined integer square root, one root bit per stage
module cpcr_sqrt import cpcr_pkg::*; #(
  parameter int AUX_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   rad_i,
  input  logic [AUX_W-1:0]  aux_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [AUX_W-1:0]  aux_o
);

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [STEPS];
  logic [ROOT_W-1:0] root_q [STEPS];
  logic [SQ_W-1:0]   rad_q  [STEPS];
  logic [AUX_W-1:0]  aux_q  [STEPS];
  logic [STEPS-1:0]  vld_q;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic [REM_W-1:0]  rem_p, rem_sh, trial, rem_d;
    logic [ROOT_W-1:0] root_p, root_d;
    logic [SQ_W-1:0]   rad_p;
    logic [AUX_W-1:0]  aux_p;
    logic              vld_p, ge;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign aux_p  = aux_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
      assign rad_p  = rad_q[g-1];
      assign aux_p  = aux_q[g-1];
      assign vld_p  = vld_q[g-1];
    end

    always_comb begin
      rem_sh = {rem_p[REM_W-3:0], rad_p[SQ_W-1:SQ_W-2]};
      trial  = {1'b0, root_p, 2'b01};
      ge     = (rem_sh >= trial);
      rem_d  = ge ? (rem_sh - trial) : rem_sh;
      root_d = {root_p[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        rad_q[g]  <= {rad_p[SQ_W-3:0], 2'b00};
        aux_q[g]  <= aux_p;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign aux_o   = aux_q[STEPS-1];

endmodule

### rtl/core/cpcr_div.sv
// pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage
module cpcr_div import cpcr_pkg::*; #(
  parameter int AUX_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_x_i,
  input  logic [NUM_W-1:0]  num_y_i,
  input  logic [ROOT_W-1:0] den_i,
  input  logic [AUX_W-1:0]  aux_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_x_o,
  output logic [QUO_W-1:0]  quo_y_o,
  output logic [AUX_W-1:0]  aux_o
);

  localparam int STEPS = QUO_W;
  localparam int REM_W = ROOT_W + 1;

  logic [REM_W-1:0]  rx_q [STEPS];
  logic [REM_W-1:0]  ry_q [STEPS];
  logic [QUO_W-1:0]  lx_q [STEPS];
  logic [QUO_W-1:0]  ly_q [STEPS];
  logic [QUO_W-1:0]  qx_q [STEPS];
  logic [QUO_W-1:0]  qy_q [STEPS];
  logic [ROOT_W-1:0] den_q [STEPS];
  logic [AUX_W-1:0]  aux_q [STEPS];
  logic [STEPS-1:0]  vld_q;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic [REM_W-1:0]  rx_p, ry_p, rx_sh, ry_sh, rx_d, ry_d, den_ext;
    logic [QUO_W-1:0]  lx_p, ly_p, qx_p, qy_p;
    logic [ROOT_W-1:0] den_p;
    logic [AUX_W-1:0]  aux_p;
    logic              vld_p, gx, gy;

    if (g == 0) begin : g_first
      // high part is below the divisor since the quotient fits QUO_W bits
      assign rx_p  = {1'b0, num_x_i[NUM_W-1:QUO_W]};
      assign ry_p  = {1'b0, num_y_i[NUM_W-1:QUO_W]};
      assign lx_p  = num_x_i[QUO_W-1:0];
      assign ly_p  = num_y_i[QUO_W-1:0];
      assign qx_p  = '0;
      assign qy_p  = '0;
      assign den_p = den_i;
      assign aux_p = aux_i;
      assign vld_p = valid_i;
    end else begin : g_next
      assign rx_p  = rx_q[g-1];
      assign ry_p  = ry_q[g-1];
      assign lx_p  = lx_q[g-1];
      assign ly_p  = ly_q[g-1];
      assign qx_p  = qx_q[g-1];
      assign qy_p  = qy_q[g-1];
      assign den_p = den_q[g-1];
      assign aux_p = aux_q[g-1];
      assign vld_p = vld_q[g-1];
    end

    always_comb begin
      den_ext = {1'b0, den_p};
      rx_sh   = {rx_p[REM_W-2:0], lx_p[QUO_W-1]};
      ry_sh   = {ry_p[REM_W-2:0], ly_p[QUO_W-1]};
      gx      = (rx_sh >= den_ext);
      gy      = (ry_sh >= den_ext);
      rx_d    = gx ? (rx_sh - den_ext) : rx_sh;
      ry_d    = gy ? (ry_sh - den_ext) : ry_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[g]  <= rx_d;
        ry_q[g]  <= ry_d;
        lx_q[g]  <= {lx_p[QUO_W-2:0], 1'b0};
        ly_q[g]  <= {ly_p[QUO_W-2:0], 1'b0};
        qx_q[g]  <= {qx_p[QUO_W-2:0], gx};
        qy_q[g]  <= {qy_p[QUO_W-2:0], gy};
        den_q[g] <= den_p;
        aux_q[g] <= aux_p;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign quo_x_o = qx_q[STEPS-1];
  assign quo_y_o = qy_q[STEPS-1];
  assign aux_o   = aux_q[STEPS-1];

endmodule

### tb/sv/cpcr_tb_if.sv
// testbench note: the request channel interfaces come from rtl/core/cpcr_if.sv
package cpcr_tb_pkg;
  import cpcr_pkg::*;

  // expected results of resolved circle pairs, checked in arrival order
  class resolve_scoreboard;
    logic [RAD_W-1:0] radius;
    out_t             pending_q[$];
    int               n_errors;
    int               n_checked;

    function new();
      radius = RADIUS_RESET;
      n_errors = 0;
      n_checked = 0;
    endfunction

    static function logic [32:0] root66(logic [65:0] v);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [33:0] root;
      int          p;
      rem = '0;
      root = '0;
      for (p = 64; p >= 0; p -= 2) begin
        rem = (rem << 2) | 68'(v[p+:2]);
        trial = (68'(root) << 2) | 68'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 34'd1;
        end else begin
          root = root << 1;
        end
      end
      return root[32:0];
    endfunction

    static function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    static function logic signed [31:0] damp(logic signed [31:0] v);
      logic signed [63:0] w;
      w = 64'(v) * 64'sd99;
      return 32'(w / 64'sd100);
    endfunction

    function logic signed [63:0] push_off(logic signed [63:0] d, logic signed [63:0] len);
      logic signed [127:0] num;
      if (len == 0) return 64'sd0;
      num = 128'(d) * $signed({1'b0, 100'(radius)});
      return 64'(num / 128'(len)) - d / 64'sd2;
    endfunction

    function void note_pair(in_t p);
      logic signed [63:0] dx, dy, len, ox, oy;
      logic [32:0]        mx, my;
      logic [65:0]        sq;
      out_t               r;
      dx = 64'(p.pos_a_x) - 64'(p.pos_b_x);
      dy = 64'(p.pos_a_y) - 64'(p.pos_b_y);
      // squares taken on the unsigned magnitudes so nothing wraps at 64 bits
      mx = dx[63] ? 33'(-dx) : 33'(dx);
      my = dy[63] ? 33'(-dy) : 33'(dy);
      sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
      len = $signed({31'd0, root66(sq)});
      ox = push_off(dx, len);
      oy = push_off(dy, len);
      r.new_pos_a_x = clamp32(64'(p.pos_a_x) + ox);
      r.new_pos_a_y = clamp32(64'(p.pos_a_y) + oy);
      r.new_pos_b_x = clamp32(64'(p.pos_b_x) - ox);
      r.new_pos_b_y = clamp32(64'(p.pos_b_y) - oy);
      r.new_vel_a_x = damp(p.vel_a_x);
      r.new_vel_a_y = damp(p.vel_a_y);
      r.new_vel_b_x = damp(p.vel_b_x);
      r.new_vel_b_y = damp(p.vel_b_y);
      pending_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_errors++;
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (got.new_pos_a_x !== e.new_pos_a_x) report("new_pos_a_x", e.new_pos_a_x, got.new_pos_a_x);
      if (got.new_pos_a_y !== e.new_pos_a_y) report("new_pos_a_y", e.new_pos_a_y, got.new_pos_a_y);
      if (got.new_pos_b_x !== e.new_pos_b_x) report("new_pos_b_x", e.new_pos_b_x, got.new_pos_b_x);
      if (got.new_pos_b_y !== e.new_pos_b_y) report("new_pos_b_y", e.new_pos_b_y, got.new_pos_b_y);
      if (got.new_vel_a_x !== e.new_vel_a_x) report("new_vel_a_x", e.new_vel_a_x, got.new_vel_a_x);
      if (got.new_vel_a_y !== e.new_vel_a_y) report("new_vel_a_y", e.new_vel_a_y, got.new_vel_a_y);
      if (got.new_vel_b_x !== e.new_vel_b_x) report("new_vel_b_x", e.new_vel_b_x, got.new_vel_b_x);
      if (got.new_vel_b_y !== e.new_vel_b_y) report("new_vel_b_y", e.new_vel_b_y, got.new_vel_b_y);
    endfunction

    function void report(string name, logic [31:0] e, logic [31:0] g);
      $display("%0t: %s expected %h actual %h", $time, name, e, g);
      n_errors++;
    endfunction
  endclass
endpackage

### tb/sv/tb_circle_pair_collision_resolve_unit.sv
// testbench top: random and directed circle pairs checked against a local predictor
module tb_circle_pair_collision_resolve_unit;
  import cpcr_pkg::*;
  import cpcr_tb_pkg::*;

  localparam int LATENCY = 65;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [RAD_W-1:0] cfg_wdata_i;

  cpcr_in_if  in_if ();
  cpcr_out_if out_if ();

  circle_pair_collision_resolve_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  resolve_scoreboard sb;
  int  n_sent;
  int  n_zero_dist;
  bit  hold_off;   // receiver stalls for a long stretch while this is set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // random gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // extreme-heavy random word
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  // sink side: random ready, plus one long hold-off window
  initial begin
    int g;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_if.ready <= 1'b0;
        @(posedge clk_i);
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_if.ready <= 1'b1;
          @(posedge clk_i);
        end else begin
          out_if.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // one circle pair request, then an optional random gap
  task automatic send_pair(in_t p, bit allow_gap);
    int g;
    in_if.data  <= p;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_pair(p);
    n_sent++;
    if (p.pos_a_x == p.pos_b_x && p.pos_a_y == p.pos_b_y) n_zero_dist++;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic go_idle();
    int guard;
    in_if.valid <= 1'b0;
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.radius = r;
    @(posedge clk_i);
  endtask

  function automatic in_t rand_pair(int mode);
    in_t p;
    p.vel_a_x = rand_word();
    p.vel_a_y = rand_word();
    p.vel_b_x = rand_word();
    p.vel_b_y = rand_word();
    case (mode)
      // nearby circles, the normal collision case
      0: begin
        p.pos_a_x = $urandom();
        p.pos_a_y = $urandom();
        p.pos_b_x = p.pos_a_x + $signed(32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000);
        p.pos_b_y = p.pos_a_y + $signed(32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000);
      end
      // coincident centers
      1: begin
        p.pos_a_x = rand_word();
        p.pos_a_y = rand_word();
        p.pos_b_x = p.pos_a_x;
        p.pos_b_y = p.pos_a_y;
      end
      default: begin
        p.pos_a_x = rand_word();
        p.pos_a_y = rand_word();
        p.pos_b_x = rand_word();
        p.pos_b_y = rand_word();
      end
    endcase
    return p;
  endfunction

  initial begin
    in_t p;
    int  k, m;
    int  phase;
    logic [RAD_W-1:0] radii [5];
    sb = new();
    n_sent = 0;
    n_zero_dist = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset radius first
    p = '0;
    send_pair(p, 1'b0);                       // coincident at origin
    p.pos_a_x = 32'sh00010000; p.pos_b_x = 32'sh0;
    send_pair(p, 1'b0);                       // small overlap on x
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh80000000, 32'shffffffff, 32'sh00000001};
    send_pair(p, 1'b0);                       // widest distance
    p = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
          32'sh80000000, 32'sh7fffffff, 32'sh00000064, 32'shffffff9c};
    send_pair(p, 1'b0);
    p = '{32'sh7fffff00, 32'sh0, 32'sh7ffffe00, 32'sh0, 0, 0, 0, 0};
    send_pair(p, 1'b0);                       // A pushed past the top, saturates
    p = '{32'sh80000100, 32'sh0, 32'sh80000200, 32'sh0, 0, 0, 0, 0};
    send_pair(p, 1'b0);                       // A pushed past the bottom
    p = '{32'sh12345678, 32'shedcba987, 32'sh12345678, 32'shedcba987,
          32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send_pair(p, 1'b0);                       // coincident away from origin
    go_idle();

    radii = '{27'h7ffffff, 27'd0, 27'd1, 27'd65536, 27'h4000000};
    foreach (radii[r]) begin
      write_radius(radii[r]);
      p = '{32'sh7fffffff, 32'sh0, 32'sh80000000, 32'sh0, 0, 0, 0, 0};
      send_pair(p, 1'b0);
      p = '{32'sh00000003, 32'sh00000004, 32'sh0, 32'sh0, 100, -100, 1, -1};
      send_pair(p, 1'b0);
      go_idle();
    end

    // random phases, radius changed between them
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_radius(RADIUS_RESET);
        1: write_radius(27'h7ffffff);
        2: write_radius(27'd0);
        default: write_radius(RAD_W'($urandom_range(0, 27'h7ffffff)));
      endcase
      for (k = 0; k < 170; k++) begin
        m = $urandom_range(0, 9);
        p = rand_pair(m < 6 ? 0 : (m < 7 ? 1 : 2));
        // long receiver stall in the second phase, sender keeps pushing
        if (phase == 1 && k == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        send_pair(p, (phase != 3) && (k % 50 > 10));
      end
      go_idle();
    end

    $display("sent %0d circle pairs, checked %0d results, %0d coincident pairs",
             n_sent, sb.n_checked, n_zero_dist);
    $display("radius extremes, saturation and a long output stall were covered");
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
